FILE: design/assert_macros.svh
// assertion macros shared by the disjoint-set union engine modules
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define DSU_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define DSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/dsu_pkg.sv
// types, codes and the control store of the disjoint-set union engine
// no dependencies; imported by the sequencer, the datapath and the top level
package dsu_pkg;

   // fixed field widths of the beats
   localparam int NODE_W     = 10;
   localparam int SIZE_OUT_W = 11;

   typedef struct packed {
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic                  joined;
      logic [NODE_W-1:0]     root_after;
      logic [SIZE_OUT_W-1:0] set_size_after;
   } rsp_type;

   // datapath actions
   localparam int ACT_W = 4;
   typedef logic [ACT_W-1:0] act_type;
   localparam act_type ACT_CLEAR      = 4'd0;
   localparam act_type ACT_IDLE       = 4'd1;
   localparam act_type ACT_FIND_START = 4'd2;
   localparam act_type ACT_FIND_STEP  = 4'd3;
   localparam act_type ACT_COMP_START = 4'd4;
   localparam act_type ACT_COMP_STEP  = 4'd5;
   localparam act_type ACT_SIZE_A     = 4'd6;
   localparam act_type ACT_SIZE_B     = 4'd7;
   localparam act_type ACT_MERGE      = 4'd8;

   // which node a walk works on
   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;

   // jump conditions
   localparam int COND_W = 3;
   typedef logic [COND_W-1:0] cond_type;
   localparam cond_type COND_ALWAYS         = 3'd0;
   localparam cond_type COND_NOT_GO         = 3'd1;
   localparam cond_type COND_NOT_ROOT       = 3'd2;
   localparam cond_type COND_NOT_AT_ROOT    = 3'd3;
   localparam cond_type COND_NOT_CLEAR_LAST = 3'd4;

   // step addresses of the control store
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_CLEAR    = 4'd0;
   localparam step_type STEP_IDLE     = 4'd1;
   localparam step_type STEP_FIND_A   = 4'd2;
   localparam step_type STEP_WALK_A   = 4'd3;
   localparam step_type STEP_COMP_A   = 4'd4;
   localparam step_type STEP_CWALK_A  = 4'd5;
   localparam step_type STEP_FIND_B   = 4'd6;
   localparam step_type STEP_WALK_B   = 4'd7;
   localparam step_type STEP_COMP_B   = 4'd8;
   localparam step_type STEP_CWALK_B  = 4'd9;
   localparam step_type STEP_SIZE_A   = 4'd10;
   localparam step_type STEP_SIZE_B   = 4'd11;
   localparam step_type STEP_MERGE    = 4'd12;

   // control word as seen by the datapath
   typedef struct packed {
      act_type act;
      logic    sel;
   } dp_ctrl_type;

   // status flags back to the sequencer
   typedef struct packed {
      logic go;
      logic not_root;
      logic not_at_root;
      logic clear_last;
   } dp_status_type;

   // one control store word: jump to target when cond holds, else fall through
   typedef struct packed {
      dp_ctrl_type ctrl;
      cond_type    cond;
      step_type    target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         STEP_CLEAR:   w = '{ctrl: '{act: ACT_CLEAR, sel: SEL_A},
                             cond: COND_NOT_CLEAR_LAST, target: STEP_CLEAR};
         STEP_IDLE:    w = '{ctrl: '{act: ACT_IDLE, sel: SEL_A},
                             cond: COND_NOT_GO, target: STEP_IDLE};
         STEP_FIND_A:  w = '{ctrl: '{act: ACT_FIND_START, sel: SEL_A},
                             cond: COND_NOT_GO, target: STEP_WALK_A};
         STEP_WALK_A:  w = '{ctrl: '{act: ACT_FIND_STEP, sel: SEL_A},
                             cond: COND_NOT_ROOT, target: STEP_WALK_A};
         STEP_COMP_A:  w = '{ctrl: '{act: ACT_COMP_START, sel: SEL_A},
                             cond: COND_ALWAYS, target: STEP_CWALK_A};
         STEP_CWALK_A: w = '{ctrl: '{act: ACT_COMP_STEP, sel: SEL_A},
                             cond: COND_NOT_AT_ROOT, target: STEP_CWALK_A};
         STEP_FIND_B:  w = '{ctrl: '{act: ACT_FIND_START, sel: SEL_B},
                             cond: COND_ALWAYS, target: STEP_WALK_B};
         STEP_WALK_B:  w = '{ctrl: '{act: ACT_FIND_STEP, sel: SEL_B},
                             cond: COND_NOT_ROOT, target: STEP_WALK_B};
         STEP_COMP_B:  w = '{ctrl: '{act: ACT_COMP_START, sel: SEL_B},
                             cond: COND_ALWAYS, target: STEP_CWALK_B};
         STEP_CWALK_B: w = '{ctrl: '{act: ACT_COMP_STEP, sel: SEL_B},
                             cond: COND_NOT_AT_ROOT, target: STEP_CWALK_B};
         STEP_SIZE_A:  w = '{ctrl: '{act: ACT_SIZE_A, sel: SEL_A},
                             cond: COND_ALWAYS, target: STEP_SIZE_B};
         STEP_SIZE_B:  w = '{ctrl: '{act: ACT_SIZE_B, sel: SEL_B},
                             cond: COND_ALWAYS, target: STEP_MERGE};
         STEP_MERGE:   w = '{ctrl: '{act: ACT_MERGE, sel: SEL_B},
                             cond: COND_ALWAYS, target: STEP_IDLE};
         default:      w = '{ctrl: '{act: ACT_IDLE, sel: SEL_A},
                             cond: COND_ALWAYS, target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: design/dsu_sequencer.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on dsu_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsu_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  dsu_pkg::dp_status_type status,
   output dsu_pkg::dp_ctrl_type   ctrl
);
   import dsu_pkg::*;

   step_type  step_ff, step_in;
   ucode_type word;
   logic      jump;

   // current control word
   assign word = ucode_rom(step_ff);
   assign ctrl = word.ctrl;

   // jump condition select
   always_comb begin
      case (word.cond)
         COND_ALWAYS:         jump = 1'b1;
         COND_NOT_GO:         jump = !status.go;
         COND_NOT_ROOT:       jump = status.not_root;
         COND_NOT_AT_ROOT:    jump = status.not_at_root;
         COND_NOT_CLEAR_LAST: jump = !status.clear_last;
         default:             jump = 1'b0;
      endcase
      step_in = jump ? word.target : step_ff + STEP_W'(1);
   end

   // step counter, starts with the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

   // an accepted in-range beat always starts the walk of node a
   `DSU_ASSERT_NEXT(a_go_starts_walk, clock, reset,
      (step_ff == STEP_IDLE) && status.go, step_ff == STEP_FIND_A,
      "accepted beat did not start the walk")

   // a walk step only repeats while the root is not reached
   `DSU_ASSERT_NEXT(a_walk_exit, clock, reset,
      (step_ff == STEP_WALK_A) && !status.not_root, step_ff == STEP_COMP_A,
      "walk of node a did not leave at its root")

endmodule

FILE: design/dsu_datapath.sv
// datapath: parent and size memories, walk registers and result register
// depends on dsu_pkg and assert_macros.svh; driven by dsu_sequencer
`include "assert_macros.svh"

module dsu_datapath #(
   parameter int NODES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dsu_pkg::dp_ctrl_type   ctrl,
   output dsu_pkg::dp_status_type status,
   input  logic                   start,
   input  dsu_pkg::req_type       req_data,
   output logic                   rsp_strobe,
   output dsu_pkg::rsp_type       rsp_data
);
   import dsu_pkg::*;

   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int SIZE_W = $clog2(NODES + 1);

   // memories
   logic [IDX_W-1:0]  parent_mem [NODES];
   logic [SIZE_W-1:0] size_mem   [NODES];

   logic              p_we, s_we;
   logic [IDX_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata_ff;
   logic [IDX_W-1:0]  s_waddr, s_raddr;
   logic [SIZE_W-1:0] s_wdata, s_rdata_ff;

   // walk registers
   logic [IDX_W-1:0]  a_ff, a_in, b_ff, b_in, cur_ff, cur_in;
   logic [IDX_W-1:0]  ra_ff, ra_in, rb_ff, rb_in, clr_ff, clr_in;
   logic [SIZE_W-1:0] sa_ff, sa_in;

   // result register
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              idle, accept, in_range, merge_now;
   logic [IDX_W-1:0]  node_sel, root_sel, small_root, big_root;
   logic              same, swap;
   logic [SIZE_W:0]   sum_wide;
   logic [SIZE_W-1:0] sum;

   // handshake and range check
   assign idle     = (ctrl.act == ACT_IDLE);
   assign accept   = start && idle;
   assign in_range = (32'(req_data.node_a) < NODES) && (32'(req_data.node_b) < NODES);

   // operand select for the current walk
   assign node_sel = (ctrl.sel == SEL_B) ? b_ff : a_ff;
   assign root_sel = (ctrl.sel == SEL_B) ? rb_ff : ra_ff;

   // union by size
   assign same       = (ra_ff == rb_ff);
   assign swap       = (sa_ff > s_rdata_ff);
   assign small_root = swap ? rb_ff : ra_ff;
   assign big_root   = swap ? ra_ff : rb_ff;
   assign sum_wide   = {1'b0, sa_ff} + {1'b0, s_rdata_ff};
   assign sum        = sum_wide[SIZE_W-1:0];
   assign merge_now  = (ctrl.act == ACT_MERGE);

   // status flags
   assign status.go          = accept && in_range;
   assign status.not_root    = (p_rdata_ff != cur_ff);
   assign status.not_at_root = (cur_ff != root_sel);
   assign status.clear_last  = (clr_ff == IDX_W'(NODES - 1));

   // action decode
   always_comb begin
      p_we          = 1'b0;
      p_waddr       = cur_ff;
      p_wdata       = root_sel;
      p_raddr       = cur_ff;
      s_we          = 1'b0;
      s_waddr       = big_root;
      s_wdata       = sum;
      s_raddr       = ra_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      sa_in         = sa_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (ctrl.act)
         ACT_CLEAR: begin
            p_we    = 1'b1;
            p_waddr = clr_ff;
            p_wdata = clr_ff;
            s_we    = 1'b1;
            s_waddr = clr_ff;
            s_wdata = SIZE_W'(1);
            clr_in  = clr_ff + IDX_W'(1);
         end
         ACT_IDLE: begin
            if (accept) begin
               a_in = IDX_W'(req_data.node_a);
               b_in = IDX_W'(req_data.node_b);
               // out of range beats answer at once with zero fields
               if (!in_range) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
               end
            end
         end
         ACT_FIND_START, ACT_COMP_START: begin
            p_raddr = node_sel;
            cur_in  = node_sel;
         end
         ACT_FIND_STEP: begin
            // follow one link per cycle until a node points at itself
            if (status.not_root) begin
               cur_in  = p_rdata_ff;
               p_raddr = p_rdata_ff;
            end else if (ctrl.sel == SEL_B) begin
               rb_in = cur_ff;
            end else begin
               ra_in = cur_ff;
            end
         end
         ACT_COMP_STEP: begin
            // repoint the visited node at the root and move on
            if (status.not_at_root) begin
               p_we    = 1'b1;
               p_waddr = cur_ff;
               p_wdata = root_sel;
               cur_in  = p_rdata_ff;
               p_raddr = p_rdata_ff;
            end
         end
         ACT_SIZE_A: begin
            s_raddr = ra_ff;
         end
         ACT_SIZE_B: begin
            sa_in   = s_rdata_ff;
            s_raddr = rb_ff;
         end
         ACT_MERGE: begin
            rsp_strobe_in = 1'b1;
            if (same) begin
               rsp_data_in.joined         = 1'b0;
               rsp_data_in.root_after     = NODE_W'(rb_ff);
               rsp_data_in.set_size_after = SIZE_OUT_W'(s_rdata_ff);
            end else begin
               p_we    = 1'b1;
               p_waddr = small_root;
               p_wdata = big_root;
               s_we    = 1'b1;
               s_waddr = big_root;
               s_wdata = sum;
               rsp_data_in.joined         = 1'b1;
               rsp_data_in.root_after     = NODE_W'(big_root);
               rsp_data_in.set_size_after = SIZE_OUT_W'(sum);
            end
         end
         default: begin
         end
      endcase
   end

   // parent memory, registered read
   always_ff @(posedge clock) begin
      if (p_we) begin
         parent_mem[p_waddr] <= p_wdata;
      end
      p_rdata_ff <= parent_mem[p_raddr];
   end

   // size memory, registered read
   always_ff @(posedge clock) begin
      if (s_we) begin
         size_mem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= size_mem[s_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      cur_ff      <= cur_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      sa_ff       <= sa_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a result beat follows only a merge step or an out of range accept
   `DSU_ASSERT_IMPLIES(a_strobe_source, clock, reset,
      rsp_strobe_ff, $past(merge_now || (accept && !in_range)),
      "result beat without a merge or a rejected beat")

   // merged set never holds more than the whole forest
   `DSU_ASSERT_IMPLIES(a_sum_bound, clock, reset,
      merge_now && !same, sum_wide <= (SIZE_W + 1)'(NODES),
      "merged set size exceeds the node count")

endmodule

FILE: design/disjoint_set_union_engine_top.sv
// top level of the disjoint-set union engine (union by size, path compression)
// depends on dsu_pkg, dsu_sequencer and dsu_datapath
//
//   channel   ports                          handshake
//   request   start, busy, req_data          beat taken when start high, busy low
//   response  rsp_strobe, rsp_data           beat valid for one cycle, no backpressure
//
// after reset a clearing pass writes both tables, busy high
// an in-range beat keeps busy high while the paths from node_a and node_b to
// their roots are walked, the path of node_b after the path of node_a is
// compressed; the result beat comes in the cycle busy drops
// each path is walked twice, one link per cycle through the parent memory port
// an out of range beat answers in the next cycle and busy stays low
module disjoint_set_union_engine_top #(
   parameter int NODES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dsu_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dsu_pkg::rsp_type rsp_data
);
   import dsu_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   // busy whenever the sequencer is off its idle step
   assign busy = (ctrl.act != ACT_IDLE);

   // control store sequencer
   dsu_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // tables and walk datapath
   dsu_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .start      (start),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
